@@ rtl/core/ett_pkg.sv @@
// ----------------------------------------------------------------------------
// Entity text tokenizer package
// Shared types, event codes and character constants for the tokenizer.
// ----------------------------------------------------------------------------
package ett_pkg;

  // Default depth of the result queue. It must be a power of two, at least 4.
  localparam int unsigned FIFO_DEPTH = 4;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_TOP     = 3'd0,
    MODE_BLOCK   = 3'd1,
    MODE_KEY     = 3'd2,
    MODE_KEY_ESC = 3'd3,
    MODE_MID     = 3'd4,
    MODE_VAL     = 3'd5,
    MODE_VAL_ESC = 3'd6,
    MODE_HALT    = 3'd7
  } mode_e;

  // Event kinds carried by a result.
  typedef enum logic [2:0] {
    KIND_KEY_CHAR  = 3'd0,
    KIND_KEY_END   = 3'd1,
    KIND_VAL_CHAR  = 3'd2,
    KIND_VAL_END   = 3'd3,
    KIND_ENT_BEGIN = 3'd4,
    KIND_ENT_END   = 3'd5,
    KIND_ERROR     = 3'd6,
    KIND_DONE      = 3'd7
  } kind_e;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_NO_QUOTE   = 2'd1,
    ERR_OPEN_STR   = 2'd2,
    ERR_OPEN_BLOCK = 2'd3
  } err_e;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // One result as it sits in the queue.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    err_e       code;
    logic       last_res;
  } result_t;

  // Everything the decoder produces for one byte.
  typedef struct packed {
    mode_e      next_mode;
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } dec_t;

endpackage

@@ rtl/core/ett_decode.sv @@
// ----------------------------------------------------------------------------
// Entity text tokenizer byte decoder
// Works out the next parser mode and up to two results for one byte.
// ----------------------------------------------------------------------------
module ett_decode
  import ett_pkg::*;
(
  input  mode_e      mode_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output dec_t       dec_o
);

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] b);
    if (b == CH_N) begin
      unescape = CH_NL;
    end else if (b == CH_T) begin
      unescape = CH_TAB;
    end else begin
      unescape = b;
    end
  endfunction

  mode_e      nm;
  err_e       err;
  logic       has_ev;
  kind_e      ev_kind;
  logic [7:0] ev_ch;
  result_t    prim;
  result_t    done_res;

  // Per-mode reaction to the byte.
  always_comb begin
    nm      = mode_i;
    err     = ERR_NONE;
    has_ev  = 1'b0;
    ev_kind = KIND_KEY_CHAR;
    ev_ch   = 8'h00;
    case (mode_i)
      MODE_TOP: begin
        if (byte_i == CH_LBRACE) begin
          has_ev  = 1'b1;
          ev_kind = KIND_ENT_BEGIN;
          nm      = MODE_BLOCK;
        end
      end
      MODE_BLOCK: begin
        if (is_space(byte_i)) begin
          nm = MODE_BLOCK;
        end else if (byte_i == CH_RBRACE) begin
          has_ev  = 1'b1;
          ev_kind = KIND_ENT_END;
          nm      = MODE_TOP;
        end else if (byte_i == CH_QUOTE) begin
          nm = MODE_KEY;
        end else begin
          err = ERR_NO_QUOTE;
        end
      end
      MODE_KEY: begin
        if (byte_i == CH_QUOTE) begin
          has_ev  = 1'b1;
          ev_kind = KIND_KEY_END;
          nm      = MODE_MID;
        end else if (byte_i == CH_BSLASH) begin
          nm = MODE_KEY_ESC;
        end else begin
          has_ev  = 1'b1;
          ev_kind = KIND_KEY_CHAR;
          ev_ch   = byte_i;
        end
      end
      MODE_KEY_ESC: begin
        has_ev  = 1'b1;
        ev_kind = KIND_KEY_CHAR;
        ev_ch   = unescape(byte_i);
        nm      = MODE_KEY;
      end
      MODE_MID: begin
        if (is_space(byte_i)) begin
          nm = MODE_MID;
        end else if (byte_i == CH_QUOTE) begin
          nm = MODE_VAL;
        end else begin
          err = ERR_NO_QUOTE;
        end
      end
      MODE_VAL: begin
        if (byte_i == CH_QUOTE) begin
          has_ev  = 1'b1;
          ev_kind = KIND_VAL_END;
          nm      = MODE_BLOCK;
        end else if (byte_i == CH_BSLASH) begin
          nm = MODE_VAL_ESC;
        end else begin
          has_ev  = 1'b1;
          ev_kind = KIND_VAL_CHAR;
          ev_ch   = byte_i;
        end
      end
      MODE_VAL_ESC: begin
        has_ev  = 1'b1;
        ev_kind = KIND_VAL_CHAR;
        ev_ch   = unescape(byte_i);
        nm      = MODE_VAL;
      end
      default: begin
        nm = mode_i;
      end
    endcase

    if (err != ERR_NONE) begin
      nm = MODE_HALT;
    end

    // At the end of the text an open string, pair or block is an error.
    if (last_i && (err == ERR_NONE)) begin
      if (nm inside {MODE_KEY, MODE_KEY_ESC, MODE_VAL, MODE_VAL_ESC}) begin
        err = ERR_OPEN_STR;
      end else if (nm == MODE_MID) begin
        err = ERR_NO_QUOTE;
      end else if (nm == MODE_BLOCK) begin
        err = ERR_OPEN_BLOCK;
      end
    end
  end

  // Assemble the results: the byte's own event or error, then text done.
  always_comb begin
    if (err != ERR_NONE) begin
      prim.kind = KIND_ERROR;
      prim.ch   = 8'h00;
      prim.code = err;
    end else begin
      prim.kind = ev_kind;
      prim.ch   = ev_ch;
      prim.code = ERR_NONE;
    end
    prim.last_res = !last_i;

    done_res.kind     = KIND_DONE;
    done_res.ch       = 8'h00;
    done_res.code     = ERR_NONE;
    done_res.last_res = 1'b1;

    dec_o.next_mode = last_i ? MODE_TOP : nm;
    dec_o.res1      = done_res;
    if ((err != ERR_NONE) || has_ev) begin
      dec_o.res0 = prim;
      dec_o.num  = last_i ? 2'd2 : 2'd1;
    end else begin
      dec_o.res0 = done_res;
      dec_o.num  = last_i ? 2'd1 : 2'd0;
    end
  end

endmodule

@@ rtl/core/ett_result_fifo.sv @@
// ----------------------------------------------------------------------------
// Entity text tokenizer result queue
// Small register queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
module ett_result_fifo
  import ett_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  dec_t    dec_i,
  output logic    room_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      push_num;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_nx;

  assign push_num  = push_i ? dec_i.num : 2'd0;
  assign pop       = valid_o && ready_i;
  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);
  assign valid_o   = (cnt_q != '0);
  assign room_o    = (cnt_q <= RoomMax);
  assign head_o    = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_num);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(push_num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Result storage: one or two entries written per cycle, when results are pushed.
  always_ff @(posedge clk_i) begin
    if (push_num != 2'd0) begin
      mem_q[wr_ptr_q] <= dec_i.res0;
    end
    if (push_num == 2'd2) begin
      mem_q[wr_ptr_nx] <= dec_i.res1;
    end
  end

endmodule

@@ rtl/core/entity_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// Entity text tokenizer
// Turns entity text, one byte a request, into key, value and entity events.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes arrive on the input channel (in_valid_i / in_ready_o) with in_last_i
//   set on the final byte of each text. Events leave on the output channel
//   (out_valid_o / out_ready_i), one result per request; out_final_o marks the
//   last result caused by a byte. A byte may cause no result, one, or two
//   (its event or error followed by text done on the final byte).
//   A byte taken into the input register is decoded and written to the result
//   queue once the queue has room for its results, and its first result is
//   then offered from the head of the queue.
//   Throughput: one byte per cycle while each byte causes at most one result
//   and the receiver takes results; the output port gives one result a cycle,
//   so the two results of a final byte leave one after the other. The input
//   register advances only when the result queue has room for two results.
//   Reset clears the parser mode to top level and empties both stages.
//   When the receiver stalls, the queue fills and in_ready_o falls; nothing is
//   lost and results keep their order.
// ----------------------------------------------------------------------------
module entity_text_tokenizer
  import ett_pkg::*;
#(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] out_kind_o,
  output logic [7:0] out_char_o,
  output logic [1:0] error_code_o,
  output logic       out_final_o
);

  logic       stg_valid_q;
  logic [7:0] stg_byte_q;
  logic       stg_last_q;
  mode_e      mode_q;
  dec_t       dec;
  logic       room;
  logic       advance;
  result_t    head;

  // The input register moves on when the queue can hold its results.
  assign advance    = stg_valid_q && room;
  assign in_ready_o = !stg_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      mode_q      <= MODE_TOP;
    end else begin
      if (in_ready_o) begin
        stg_valid_q <= in_valid_i;
      end
      if (advance) begin
        mode_q <= dec.next_mode;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_byte_q <= in_byte_i;
      stg_last_q <= in_last_i;
    end
  end

  ett_decode u_decode (
    .mode_i (mode_q),
    .byte_i (stg_byte_q),
    .last_i (stg_last_q),
    .dec_o  (dec)
  );

  ett_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (advance),
    .dec_i   (dec),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign out_kind_o   = head.kind;
  assign out_char_o   = head.ch;
  assign error_code_o = head.code;
  assign out_final_o  = head.last_res;

endmodule

@@ rtl/core/ett_checker.sv @@
// ----------------------------------------------------------------------------
// Entity text tokenizer checker
// Port-level assertions on the tokenizer's result stream.
// ----------------------------------------------------------------------------
module ett_checker
  import ett_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] out_kind_o,
  input logic [7:0] out_char_o,
  input logic [1:0] error_code_o,
  input logic       out_final_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("ett: result withdrawn while stalled");

  // An error result always carries a non-zero code, other results none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_kind_o == KIND_ERROR) == (error_code_o != ERR_NONE)))
    else $error("ett: error code does not match kind");

  // Only string character results carry a character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o != KIND_KEY_CHAR) && (out_kind_o != KIND_VAL_CHAR))
      |-> (out_char_o == 8'h00))
    else $error("ett: character on a non-character result");

  // Text done is always the last result of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o == KIND_DONE)) |-> out_final_o)
    else $error("ett: text done not marked final");

endmodule

bind entity_text_tokenizer ett_checker u_ett_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_kind_o   (out_kind_o),
  .out_char_o   (out_char_o),
  .error_code_o (error_code_o),
  .out_final_o  (out_final_o)
);
